/* hdl/fpau_pkg.sv */
package fpau_pkg;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_RSUB = 2'd2;

   localparam logic [1:0] RM_NEAREST = 2'd0;
   localparam logic [1:0] RM_ZERO = 2'd1;
   localparam logic [1:0] RM_PLUS = 2'd2;
   localparam logic [1:0] RM_MINUS = 2'd3;

   localparam logic [63:0] NAN_OUT = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] LARGEST = 64'h7fef_ffff_ffff_ffff;
   localparam logic [63:0] SMALLEST = 64'h0010_0000_0000_0000;
   localparam logic [10:0] EXP_MAX = 11'h7ff;

   typedef struct packed {
      logic nan_first;
      logic nan_second;
      logic denormal_first;
      logic denormal_second;
      logic invalid;
      logic infinity;
      logic overflow;
      logic inexact;
      logic underflow;
   } flags_type;

   // Operands aligned and ready to add, or a special result already decided.
   typedef struct packed {
      logic        special;
      logic [63:0] special_value;
      flags_type   flags;
      logic [1:0]  rm;
      logic        sign_x;
      logic        sign_y;
      logic [11:0] exp;
      logic [55:0] mx;
      logic [55:0] my;
   } align_type;

   // Sum or difference before normalization.
   typedef struct packed {
      logic        special;
      logic [63:0] special_value;
      flags_type   flags;
      logic [1:0]  rm;
      logic        sign;
      logic [11:0] exp;
      logic [56:0] sig;
   } sum_type;

   // Normalized significand with guard bits, ready to round.
   typedef struct packed {
      logic        special;
      logic [63:0] special_value;
      flags_type   flags;
      logic [1:0]  rm;
      logic        sign;
      logic signed [12:0] exp;
      logic [55:0] sig;
   } norm_type;

endpackage

/* hdl/fpau_align.sv */
module fpau_align (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [1:0]           kind,
   input  logic [63:0]          first_operand,
   input  logic [63:0]          second_operand,
   input  logic [1:0]           rm,
   output logic                 out_valid,
   output fpau_pkg::align_type  out_data
);
   import fpau_pkg::*;

   logic        valid_ff;
   align_type   data_ff;
   align_type   data_in;

   logic [10:0] ea, eb, ex, ey;
   logic [51:0] fa, fb;
   logic        nana, nanb, infa, infb, dena, denb;
   logic [63:0] x, y;
   logic        sx, sy;
   logic [55:0] mx, my, smaller, shifted;
   logic [10:0] diff;
   logic        sticky;
   logic [55:0] lost_mask;

   always_comb begin
      ea = first_operand[62:52];
      eb = second_operand[62:52];
      fa = first_operand[51:0];
      fb = second_operand[51:0];
      nana = (ea == EXP_MAX) && (fa != '0);
      nanb = (eb == EXP_MAX) && (fb != '0);
      infa = (ea == EXP_MAX) && (fa == '0);
      infb = (eb == EXP_MAX) && (fb == '0);
      dena = (ea == '0) && (fa != '0);
      denb = (eb == '0) && (fb != '0);

      if (kind == KIND_RSUB) begin
         x = second_operand;
         y = first_operand;
      end else begin
         x = first_operand;
         y = second_operand;
      end
      if (kind != KIND_ADD) begin
         y[63] = ~y[63];
      end
      ex = x[62:52];
      ey = y[62:52];
      sx = x[63];
      sy = y[63];
      mx = {1'b1, x[51:0], 3'b000};
      my = {1'b1, y[51:0], 3'b000};

      data_in = '0;
      data_in.rm = rm;
      data_in.flags.nan_first = nana;
      data_in.flags.nan_second = nanb;
      data_in.flags.denormal_first = dena;
      data_in.flags.denormal_second = denb;
      data_in.flags.inexact = (dena && !infb) || (denb && !infa);
      data_in.sign_x = sx;
      data_in.sign_y = sy;

      if (ex >= ey) begin
         diff = ex - ey;
         smaller = my;
      end else begin
         diff = ey - ex;
         smaller = mx;
      end
      lost_mask = '0;
      if (diff >= 11'd56) begin
         shifted = '0;
         sticky = 1'b1;
      end else begin
         lost_mask = ~({56{1'b1}} << diff[5:0]);
         shifted = smaller >> diff[5:0];
         sticky = (smaller & lost_mask) != '0;
      end
      shifted[0] = shifted[0] | (sticky && diff != '0);

      if (ex >= ey) begin
         data_in.exp = {1'b0, ex};
         data_in.mx = mx;
         data_in.my = shifted;
      end else begin
         data_in.exp = {1'b0, ey};
         data_in.mx = shifted;
         data_in.my = my;
      end

      if (nana || nanb) begin
         data_in.special = 1'b1;
         data_in.special_value = NAN_OUT;
         data_in.flags.inexact = 1'b0;
         data_in.flags.invalid = (nana && !fa[51]) || (nanb && !fb[51]);
      end else if (ex == EXP_MAX || ey == EXP_MAX) begin
         data_in.special = 1'b1;
         if (ex == EXP_MAX && ey == EXP_MAX && sx != sy) begin
            data_in.special_value = NAN_OUT;
            data_in.flags.invalid = 1'b1;
         end else begin
            data_in.flags.infinity = 1'b1;
            data_in.special_value = {(ex == EXP_MAX) ? sx : sy, EXP_MAX, 52'd0};
         end
      end else if (ex == '0 && ey == '0) begin
         data_in.special = 1'b1;
         data_in.special_value = {(sx == sy) ? sx : (rm == RM_MINUS), 63'd0};
      end else if (ex == '0) begin
         data_in.special = 1'b1;
         data_in.special_value = y;
      end else if (ey == '0) begin
         data_in.special = 1'b1;
         data_in.special_value = x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

/* hdl/fpau_addsub.sv */
module fpau_addsub (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  fpau_pkg::align_type  in_data,
   output logic                 out_valid,
   output fpau_pkg::sum_type    out_data
);
   import fpau_pkg::*;

   logic     valid_ff;
   sum_type  data_ff;
   sum_type  data_in;

   always_comb begin
      data_in.special = in_data.special;
      data_in.special_value = in_data.special_value;
      data_in.flags = in_data.flags;
      data_in.rm = in_data.rm;
      data_in.exp = in_data.exp;
      if (in_data.sign_x == in_data.sign_y) begin
         data_in.sign = in_data.sign_x;
         data_in.sig = {1'b0, in_data.mx} + {1'b0, in_data.my};
      end else if (in_data.mx >= in_data.my) begin
         data_in.sign = in_data.sign_x;
         data_in.sig = {1'b0, in_data.mx - in_data.my};
      end else begin
         data_in.sign = in_data.sign_y;
         data_in.sig = {1'b0, in_data.my - in_data.mx};
      end
      if (!in_data.special && in_data.sign_x != in_data.sign_y
          && in_data.mx == in_data.my) begin
         data_in.special = 1'b1;
         data_in.special_value = {in_data.rm == RM_MINUS, 63'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

/* hdl/fpau_normalize.sv */
module fpau_normalize (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  fpau_pkg::sum_type    in_data,
   output logic                 out_valid,
   output fpau_pkg::norm_type   out_data
);
   import fpau_pkg::*;

   logic      valid_ff;
   norm_type  data_ff;
   norm_type  data_in;
   logic [5:0] lz;
   logic      found;

   always_comb begin
      lz = '0;
      found = 1'b0;
      for (int i = 55; i >= 0; i--) begin
         if (!found && in_data.sig[i]) begin
            found = 1'b1;
            lz = 6'(55 - i);
         end
      end
      data_in.special = in_data.special;
      data_in.special_value = in_data.special_value;
      data_in.flags = in_data.flags;
      data_in.rm = in_data.rm;
      data_in.sign = in_data.sign;
      if (in_data.sig[56]) begin
         data_in.sig = in_data.sig[56:1] | {55'd0, in_data.sig[0]};
         data_in.exp = $signed({1'b0, in_data.exp}) + 13'sd1;
      end else begin
         data_in.sig = in_data.sig[55:0] << lz;
         data_in.exp = $signed({1'b0, in_data.exp}) - $signed({7'd0, lz});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

/* hdl/fpau_round.sv */
module fpau_round (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  fpau_pkg::norm_type   in_data,
   output logic                 out_valid,
   output logic [63:0]          out_value,
   output fpau_pkg::flags_type  out_flags
);
   import fpau_pkg::*;

   logic        valid_ff;
   logic [63:0] value_ff, value_in;
   flags_type   flags_ff, flags_in;
   logic [53:0] man;
   logic [2:0]  rem;
   logic        inc, away;
   logic signed [12:0] exp;
   logic        s;

   always_comb begin
      s = in_data.sign;
      rem = in_data.sig[2:0];
      away = (in_data.rm == RM_PLUS && !s) || (in_data.rm == RM_MINUS && s);
      inc = (in_data.rm == RM_NEAREST && (rem > 3'd4 || (rem == 3'd4 && in_data.sig[3])))
            || (away && rem != '0);
      man = {1'b0, in_data.sig[55:3]} + {53'd0, inc};
      exp = in_data.exp;
      if (man[53]) begin
         man = man >> 1;
         exp = exp + 13'sd1;
      end
      flags_in = in_data.flags;
      if (in_data.special) begin
         value_in = in_data.special_value;
      end else if (in_data.exp <= 13'sd0) begin
         flags_in.underflow = 1'b1;
         flags_in.inexact = 1'b1;
         value_in = {s, 63'd0} | (away ? SMALLEST : 64'd0);
      end else if (exp >= $signed({2'b00, EXP_MAX})) begin
         flags_in.overflow = 1'b1;
         flags_in.inexact = 1'b1;
         flags_in.infinity = away || in_data.rm == RM_NEAREST;
         value_in = (away || in_data.rm == RM_NEAREST) ? {s, EXP_MAX, 52'd0}
                                                       : {s, LARGEST[62:0]};
      end else begin
         flags_in.inexact = flags_in.inexact | (rem != '0);
         value_in = {s, exp[10:0], man[51:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      value_ff <= value_in;
      flags_ff <= flags_in;
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_flags = flags_ff;

endmodule

/* hdl/fp64_add_subtract_unit.sv */
// Binary64 adder and subtractor with status flags.
// Request channel: an operation transfers when start is high and
// busy is low. busy is always low, so one operation may enter
// every cycle. req_kind selects add, first minus second, or second minus
// first.
// Response channel: rsp_valid is high for exactly one cycle with the
// result and its nine flags, after the four register stages below.
// The receiver cannot stall the unit; each result must be taken when shown.
// Four register stages: operand decode and alignment, significand add,
// leading-zero normalization, and rounding.
// Configuration: csr_valid/csr_ready write the rounding mode. csr_ready
// is always high; write it only while no operation is in flight.
// Reset clears the rounding mode to nearest even and empties the pipeline.
module fp64_add_subtract_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_first_operand,
   input  logic [63:0] req_second_operand,
   output logic        rsp_valid,
   output logic [63:0] rsp_sum_value,
   output logic        rsp_nan_first,
   output logic        rsp_nan_second,
   output logic        rsp_denormal_first,
   output logic        rsp_denormal_second,
   output logic        rsp_invalid_flag,
   output logic        rsp_infinity_flag,
   output logic        rsp_overflow_flag,
   output logic        rsp_inexact_flag,
   output logic        rsp_underflow_flag,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_rounding_mode
);
   import fpau_pkg::*;

   logic [1:0] rm_ff;
   logic       v1, v2, v3;
   align_type  d1;
   sum_type    d2;
   norm_type   d3;
   flags_type  flags;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rm_ff <= RM_NEAREST;
      end else if (csr_valid && csr_ready) begin
         rm_ff <= csr_rounding_mode;
      end
   end

   fpau_align u_align (
      .clock, .reset, .in_valid(start && !busy), .kind(req_kind),
      .first_operand(req_first_operand), .second_operand(req_second_operand),
      .rm(rm_ff), .out_valid(v1), .out_data(d1)
   );
   fpau_addsub u_addsub (
      .clock, .reset, .in_valid(v1), .in_data(d1), .out_valid(v2), .out_data(d2)
   );
   fpau_normalize u_norm (
      .clock, .reset, .in_valid(v2), .in_data(d2), .out_valid(v3), .out_data(d3)
   );
   fpau_round u_round (
      .clock, .reset, .in_valid(v3), .in_data(d3), .out_valid(rsp_valid),
      .out_value(rsp_sum_value), .out_flags(flags)
   );

   assign rsp_nan_first = flags.nan_first;
   assign rsp_nan_second = flags.nan_second;
   assign rsp_denormal_first = flags.denormal_first;
   assign rsp_denormal_second = flags.denormal_second;
   assign rsp_invalid_flag = flags.invalid;
   assign rsp_infinity_flag = flags.infinity;
   assign rsp_overflow_flag = flags.overflow;
   assign rsp_inexact_flag = flags.inexact;
   assign rsp_underflow_flag = flags.underflow;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##4 rsp_valid) else $error("result missing");
   a_nan_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_nan_first || rsp_nan_second) |-> rsp_sum_value == NAN_OUT)
      else $error("NaN result wrong");
   a_inf_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_infinity_flag |-> rsp_sum_value[62:0] == 63'h7ff0_0000_0000_0000)
      else $error("infinity result wrong");
   a_over_inexact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_overflow_flag || rsp_underflow_flag) |-> rsp_inexact_flag)
      else $error("inexact missing");

endmodule

/* verif/fp64_add_subtract_unit_tb.sv */
module fp64_add_subtract_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fpau_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1030;

   typedef struct packed {
      logic [63:0] sum_value;
      flags_type   flags;
   } outcome_type;

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] first;
      logic [63:0] second;
      logic        known;
      outcome_type outcome;
   } vector_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [63:0] req_first_operand;
   logic [63:0] req_second_operand;
   logic        rsp_valid;
   logic [63:0] rsp_sum_value;
   logic        rsp_nan_first;
   logic        rsp_nan_second;
   logic        rsp_denormal_first;
   logic        rsp_denormal_second;
   logic        rsp_invalid_flag;
   logic        rsp_infinity_flag;
   logic        rsp_overflow_flag;
   logic        rsp_inexact_flag;
   logic        rsp_underflow_flag;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_rounding_mode;

   logic [1:0]  model_mode;
   outcome_type pending_sums[$];
   int          failures;
   int          cycle_count;
   int          gap_percent;
   vector_type  directed_rows[$];

   fp64_add_subtract_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_first_operand(req_first_operand),
      .req_second_operand(req_second_operand), .rsp_valid(rsp_valid),
      .rsp_sum_value(rsp_sum_value), .rsp_nan_first(rsp_nan_first),
      .rsp_nan_second(rsp_nan_second), .rsp_denormal_first(rsp_denormal_first),
      .rsp_denormal_second(rsp_denormal_second), .rsp_invalid_flag(rsp_invalid_flag),
      .rsp_infinity_flag(rsp_infinity_flag), .rsp_overflow_flag(rsp_overflow_flag),
      .rsp_inexact_flag(rsp_inexact_flag), .rsp_underflow_flag(rsp_underflow_flag),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_rounding_mode(csr_rounding_mode)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] shift_sticky(logic [63:0] v, int n);
      if (n == 0) return v;
      if (n < 64) return (v >> n) | 64'((v << (64 - n)) != 0);
      return 64'(v != 0);
   endfunction

   function automatic outcome_type predict_sum(logic [1:0] kind, logic [63:0] a,
                                               logic [63:0] b, logic [1:0] rm);
      outcome_type r;
      logic [10:0] ea, eb, ex, ey;
      logic [51:0] fa, fb;
      logic [63:0] x, y, mx, my, sig, man;
      logic        sx, sy, s, away, inc, toinf;
      logic [2:0]  rem;
      int          e;
      r = '0;
      ea = a[62:52];
      eb = b[62:52];
      fa = a[51:0];
      fb = b[51:0];
      r.flags.nan_first = ea == EXP_MAX && fa != 0;
      r.flags.nan_second = eb == EXP_MAX && fb != 0;
      r.flags.denormal_first = ea == 0 && fa != 0;
      r.flags.denormal_second = eb == 0 && fb != 0;
      if (r.flags.nan_first || r.flags.nan_second) begin
         r.flags.invalid = (r.flags.nan_first && !fa[51]) || (r.flags.nan_second && !fb[51]);
         r.sum_value = NAN_OUT;
         return r;
      end
      if (r.flags.denormal_first && !(eb == EXP_MAX)) r.flags.inexact = 1'b1;
      if (r.flags.denormal_second && !(ea == EXP_MAX)) r.flags.inexact = 1'b1;
      x = a;
      y = b;
      if (kind == KIND_RSUB) begin
         x = b;
         y = a;
      end
      if (kind != KIND_ADD) y[63] = ~y[63];
      if (x[62:52] == 0) x = {x[63], 63'd0};
      if (y[62:52] == 0) y = {y[63], 63'd0};
      ex = x[62:52];
      ey = y[62:52];
      sx = x[63];
      sy = y[63];
      if (ex == EXP_MAX || ey == EXP_MAX) begin
         if (ex == EXP_MAX && ey == EXP_MAX && sx != sy) begin
            r.flags.invalid = 1'b1;
            r.sum_value = NAN_OUT;
            return r;
         end
         r.flags.infinity = 1'b1;
         r.sum_value = (ex == EXP_MAX) ? {sx, EXP_MAX, 52'd0} : {sy, EXP_MAX, 52'd0};
         return r;
      end
      if (ex == 0 && ey == 0) begin
         r.sum_value = {(sx == sy) ? sx : (rm == RM_MINUS), 63'd0};
         return r;
      end
      if (ex == 0) begin
         r.sum_value = y;
         return r;
      end
      if (ey == 0) begin
         r.sum_value = x;
         return r;
      end
      mx = {9'd0, 1'b1, x[51:0], 2'b0} << 1;
      my = {9'd0, 1'b1, y[51:0], 2'b0} << 1;
      if (ex > ey) begin
         my = shift_sticky(my, ex - ey);
         e = ex;
      end else if (ey > ex) begin
         mx = shift_sticky(mx, ey - ex);
         e = ey;
      end else e = ex;
      if (sx == sy) begin
         s = sx;
         sig = mx + my;
         if (sig[56]) begin
            sig = shift_sticky(sig, 1);
            e++;
         end
      end else begin
         if (mx == my) begin
            r.sum_value = {rm == RM_MINUS, 63'd0};
            return r;
         end
         if (mx > my) begin
            s = sx;
            sig = mx - my;
         end else begin
            s = sy;
            sig = my - mx;
         end
         while (!sig[55]) begin
            sig = sig << 1;
            e--;
         end
      end
      if (e <= 0) begin
         away = (rm == RM_PLUS && !s) || (rm == RM_MINUS && s);
         r.flags.underflow = 1'b1;
         r.flags.inexact = 1'b1;
         r.sum_value = {s, 63'd0} | (away ? SMALLEST : 64'd0);
         return r;
      end
      man = sig >> 3;
      rem = sig[2:0];
      inc = (rm == RM_NEAREST && (rem > 4 || (rem == 4 && man[0])))
            || (rm == RM_PLUS && !s && rem != 0) || (rm == RM_MINUS && s && rem != 0);
      if (inc) begin
         man++;
         if (man[53]) begin
            man = man >> 1;
            e++;
         end
      end
      if (e >= 2047) begin
         toinf = rm == RM_NEAREST || (rm == RM_PLUS && !s) || (rm == RM_MINUS && s);
         r.flags.inexact = 1'b1;
         r.flags.overflow = 1'b1;
         r.flags.infinity = toinf;
         r.sum_value = {s, 63'd0} | (toinf ? {1'b0, EXP_MAX, 52'd0} : LARGEST);
         return r;
      end
      if (rem != 0) r.flags.inexact = 1'b1;
      r.sum_value = {s, e[10:0], man[51:0]};
      return r;
   endfunction

   task automatic issue(logic [1:0] kind, logic [63:0] a, logic [63:0] b,
                        logic known, outcome_type outcome);
      while ($urandom_range(99) < gap_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_first_operand <= a;
      req_second_operand <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_sums.push_back(known ? outcome :
                             predict_sum(kind, a, b, model_mode));
   endtask

   task automatic set_mode(logic [1:0] mode);
      start <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_valid <= 1'b1;
      csr_rounding_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      model_mode = mode;
   endtask

   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0: v[62:52] = 11'h7ff;
         1: v[62:52] = 11'h000;
         2: v[62:52] = 11'h7fe - 11'($urandom_range(3));
         3: v[62:52] = 11'($urandom_range(4));
         4: v[51:0] = 52'($urandom_range(1)) << $urandom_range(51);
         default: v[62:52] = 11'h3ff + 11'($urandom_range(120)) - 11'd60;
      endcase
      return v;
   endfunction

   task automatic add_row(logic [1:0] k, logic [63:0] a, logic [63:0] b,
                          logic known, logic [63:0] v, flags_type f);
      vector_type row;
      row.kind = k;
      row.first = a;
      row.second = b;
      row.known = known;
      row.outcome = {v, f};
      directed_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_sums.size() == 0) begin
            $error("result transfer with nothing expected");
            failures++;
         end else begin
            want = pending_sums.pop_front();
            if (rsp_sum_value !== want.sum_value) begin
               $error("sum_value expected %h actual %h", want.sum_value, rsp_sum_value);
               failures++;
            end
            if ({rsp_nan_first, rsp_nan_second, rsp_denormal_first, rsp_denormal_second,
                 rsp_invalid_flag, rsp_infinity_flag, rsp_overflow_flag,
                 rsp_inexact_flag, rsp_underflow_flag} !== want.flags) begin
               $error("flags expected %b actual %b", want.flags,
                      {rsp_nan_first, rsp_nan_second, rsp_denormal_first,
                       rsp_denormal_second, rsp_invalid_flag, rsp_infinity_flag,
                       rsp_overflow_flag, rsp_inexact_flag, rsp_underflow_flag});
               failures++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      flags_type nf;
      nf = '0;
      failures = 0;
      cycle_count = 0;
      gap_percent = 0;
      model_mode = RM_NEAREST;
      reset <= 1'b1;
      start <= 1'b0;
      req_kind <= KIND_ADD;
      req_first_operand <= '0;
      req_second_operand <= '0;
      csr_valid <= 1'b0;
      csr_rounding_mode <= RM_NEAREST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      add_row(KIND_ADD, 64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000, 1'b1,
              64'h4000_0000_0000_0000, nf);
      add_row(KIND_SUB, 64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000, 1'b1, 64'd0, nf);
      add_row(KIND_ADD, 64'h7ff0_0000_0000_0001, 64'd0, 1'b1, NAN_OUT,
              flags_type'(9'b1_0001_0000));
      add_row(KIND_ADD, 64'd0, 64'h7ff8_0000_0000_0000, 1'b1, NAN_OUT,
              flags_type'(9'b0_1000_0000));
      add_row(KIND_ADD, 64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000, 1'b1, NAN_OUT,
              flags_type'(9'b0_0001_0000));
      add_row(KIND_SUB, 64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000, 1'b1,
              64'h7ff0_0000_0000_0000, flags_type'(9'b0_0000_1000));
      add_row(KIND_ADD, 64'h0000_0000_0000_0001, 64'h3ff0_0000_0000_0000, 1'b1,
              64'h3ff0_0000_0000_0000, flags_type'(9'b0_0100_0010));
      add_row(KIND_ADD, 64'h8000_0000_0000_0001, 64'hfff0_0000_0000_0000, 1'b1,
              64'hfff0_0000_0000_0000, flags_type'(9'b0_0100_1000));
      add_row(KIND_ADD, 64'h8000_0000_0000_0000, 64'd0, 1'b1, 64'd0, nf);
      add_row(KIND_ADD, LARGEST, LARGEST, 1'b1, 64'h7ff0_0000_0000_0000,
              flags_type'(9'b0_0000_1110));
      add_row(KIND_SUB, 64'h0010_0000_0000_0001, SMALLEST, 1'b1, 64'd0,
              flags_type'(9'b0_0000_0011));
      add_row(2'd3, 64'h4000_0000_0000_0000, 64'h3ff0_0000_0000_0000, 1'b0, '0, nf);
      add_row(KIND_RSUB, 64'h4000_0000_0000_0000, 64'h3ff0_0000_0000_0000, 1'b0, '0, nf);
      add_row(KIND_ADD, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0, '0, nf);
      add_row(KIND_ADD, 64'h3ff0_0000_0000_0000, 64'h3ca0_0000_0000_0000, 1'b0, '0, nf);
      add_row(KIND_ADD, 64'h3ff0_0000_0000_0000, 64'h3ca0_0000_0000_0001, 1'b0, '0, nf);
      add_row(KIND_SUB, 64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0001, 1'b0, '0, nf);
      add_row(KIND_ADD, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001, 1'b0, '0, nf);

      foreach (directed_rows[i])
         issue(directed_rows[i].kind, directed_rows[i].first, directed_rows[i].second,
               directed_rows[i].known, directed_rows[i].outcome);

      for (int mode = 0; mode < 4; mode++) begin
         set_mode(2'(mode));
         foreach (directed_rows[i])
            if (!directed_rows[i].known)
               issue(directed_rows[i].kind, directed_rows[i].first,
                     directed_rows[i].second, 1'b0, '0);
         issue(KIND_ADD, LARGEST, LARGEST, 1'b0, '0);
         issue(KIND_SUB, 64'h8010_0000_0000_0001, 64'h8010_0000_0000_0000, 1'b0, '0);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) set_mode(2'($urandom_range(3)));
         if (n < RANDOM_ITEMS / 3) gap_percent = 20;
         else if (n < 2 * RANDOM_ITEMS / 3) gap_percent = 84;
         else gap_percent = 0;
         issue(2'($urandom_range(3)), random_operand(), random_operand(), 1'b0, '0);
      end
      start <= 1'b0;

      while (pending_sums.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

/* filelist.f */
hdl/fpau_pkg.sv
hdl/fpau_align.sv
hdl/fpau_addsub.sv
hdl/fpau_normalize.sv
hdl/fpau_round.sv
hdl/fp64_add_subtract_unit.sv
verif/fp64_add_subtract_unit_tb.sv
